>>> rtl/gdfp_pkg.sv
// ----------------------------------------------------------------------------
// gdfp_pkg
// Shared types and constants for the five-point grayscale dilation block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdfp_pkg;

    localparam int PIXEL_W     = 8;
    localparam int LEN_CFG_W   = 11;
    localparam int CNT_CFG_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COUNT  = 1'b1;

    localparam logic [LEN_CFG_W-1:0] LINE_LENGTH_RESET = 11'd1024;
    localparam logic [CNT_CFG_W-1:0] LINE_COUNT_RESET  = 16'd1024;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // Per-item flags travelling from the position tracker down the pipe
    typedef struct packed {
        logic center_valid;
        logic frame_end;
    } gdfp_flags_t;

endpackage

`default_nettype wire

>>> rtl/gdfp_ram.sv
// ----------------------------------------------------------------------------
// gdfp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/gdfp_pos.sv
// ----------------------------------------------------------------------------
// gdfp_pos
// Configuration registers and scan position tracking; classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfp_pos #(
    parameter int MAX_LINE = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [gdfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gdfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              accept,
    input  wire logic                              frame_start,
    output logic      [$clog2(MAX_LINE)-1:0]       col,
    output gdfp_pkg::gdfp_flags_t                  flags
);

    import gdfp_pkg::*;

    localparam int CW = $clog2(MAX_LINE);
    localparam int EW = (CW + 1 > LEN_CFG_W) ? CW + 1 : LEN_CFG_W;
    localparam int RW = CNT_CFG_W + 1;

    logic [LEN_CFG_W-1:0] line_length_reg, line_length_next;
    logic [CNT_CFG_W-1:0] line_count_reg, line_count_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [CNT_CFG_W-1:0] row_reg, row_next;

    logic [EW-1:0]        len_raw;
    logic [EW-1:0]        len_eff;
    logic [CNT_CFG_W-1:0] cnt_eff;
    logic [CNT_CFG_W-1:0] row;
    logic [EW-1:0]        col_ext;
    logic                 last_col;
    logic                 last_row;

    // Register writes
    always_comb
    begin
        line_length_next = line_length_reg;
        line_count_next  = line_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINE_LENGTH: line_length_next = cfg_data[LEN_CFG_W-1:0];
                REG_LINE_COUNT:  line_count_next  = cfg_data[CNT_CFG_W-1:0];
                default:         line_length_next = line_length_reg;
            endcase
        end
    end

    // Clamp sizes to the supported range
    always_comb
    begin
        len_raw = EW'(line_length_reg);
        if (len_raw < EW'(3))
        begin
            len_eff = EW'(3);
        end
        else if (len_raw > EW'(MAX_LINE))
        begin
            len_eff = EW'(MAX_LINE);
        end
        else
        begin
            len_eff = len_raw;
        end
        cnt_eff = (line_count_reg < CNT_CFG_W'(3)) ? CNT_CFG_W'(3) : line_count_reg;
    end

    // Frame start restarts the scan at line 0, column 0
    assign col     = frame_start ? '0 : col_reg;
    assign row     = frame_start ? '0 : row_reg;
    assign col_ext = EW'(col);

    assign last_col = (col_ext + EW'(1)) >= len_eff;
    assign last_row = (RW'(row) + RW'(1)) >= RW'(cnt_eff);

    assign flags.center_valid = (row >= CNT_CFG_W'(2)) && (row < cnt_eff) &&
                                (col_ext >= EW'(2)) && (col_ext < len_eff);
    assign flags.frame_end    = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row + CNT_CFG_W'(1);
            end
            else
            begin
                col_next = col + CW'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= LINE_LENGTH_RESET;
            line_count_reg  <= LINE_COUNT_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else
        begin
            line_length_reg <= line_length_next;
            line_count_reg  <= line_count_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gdfp_window.sv
// ----------------------------------------------------------------------------
// gdfp_window
// Four window taps fed from the line store, and the five-point maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfp_window (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire gdfp_pkg::pixel_t px,
    input  wire gdfp_pkg::pixel_t rd_old,
    input  wire gdfp_pkg::pixel_t rd_new,
    output gdfp_pkg::pixel_t      best
);

    import gdfp_pkg::*;

    pixel_t tap_reg  [4];
    pixel_t tap_next [4];
    pixel_t m01;
    pixel_t m23;
    pixel_t m23p;

    assign m01  = (tap_reg[0] > tap_reg[1]) ? tap_reg[0] : tap_reg[1];
    assign m23  = (tap_reg[2] > tap_reg[3]) ? tap_reg[2] : tap_reg[3];
    assign m23p = (m23 > px) ? m23 : px;
    assign best = (m01 > m23p) ? m01 : m23p;

    // Shift in this item's line-store words after the maximum is taken
    always_comb
    begin
        tap_next = tap_reg;
        if (advance)
        begin
            tap_next[0] = tap_reg[1];
            tap_next[1] = rd_old;
            tap_next[2] = tap_reg[3];
            tap_next[3] = rd_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '{default: '0};
        end
        else
        begin
            tap_reg <= tap_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/grayscale_dilation_five_point.sv
// ----------------------------------------------------------------------------
// grayscale_dilation_five_point
// Five-point grayscale dilation over a pixel stream with one paired line store.
// ----------------------------------------------------------------------------
// Throughput: 1 item per cycle unless the result side stalls, set by the single
//   line-store port pair that reads an entry on acceptance and writes it back
//   one stage later.
// Reset: positions, window taps and the pipe clear; line_length and
//   line_count return to 1024. The line store is not cleared and holds
//   garbage until each entry is written.
// ----------------------------------------------------------------------------
`default_nettype none

module grayscale_dilation_five_point #(
    parameter int MAX_LINE = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration
    input  wire logic                              cfg_we,
    input  wire logic [gdfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gdfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Pixel channel
    input  wire logic                              pixel_valid,
    output logic                                   pixel_ready,
    input  wire logic [gdfp_pkg::PIXEL_W-1:0]      pixel,
    input  wire logic                              frame_start,
    // Result channel
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic      [gdfp_pkg::PIXEL_W-1:0]      dilated_value,
    output logic                                   center_valid,
    output logic                                   frame_end
);

    import gdfp_pkg::*;

    localparam int CW = $clog2(MAX_LINE);
    localparam int MW = 2 * PIXEL_W;

    // Stage 0: acceptance, position and line-store read
    logic              accept;
    logic [CW-1:0]     col_s0;
    gdfp_flags_t       flags_s0;

    // Stage 1: line-store data back, window update and write-back
    logic              s1_valid_reg, s1_valid_next;
    pixel_t            s1_px_reg;
    logic [CW-1:0]     s1_col_reg;
    gdfp_flags_t       s1_flags_reg;
    logic              fwd_hit_reg;
    pixel_t            fwd_old_reg;
    pixel_t            fwd_new_reg;
    logic              s1_adv;
    logic [MW-1:0]     ram_rdata;
    pixel_t            rd_old;
    pixel_t            rd_new;
    pixel_t            best;

    // Output register
    logic              result_valid_reg, result_valid_next;
    pixel_t            dilated_value_reg;
    gdfp_flags_t       out_flags_reg;

    // Stage 1 moves on whenever the output register is empty or being drained,
    // so a new item can enter while a finished result still waits.
    assign s1_adv      = s1_valid_reg && (!result_valid_reg || result_ready);
    assign pixel_ready = !s1_valid_reg || s1_adv;
    assign accept      = pixel_valid && pixel_ready;

    gdfp_pos #(
        .MAX_LINE (MAX_LINE)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .frame_start (frame_start),
        .col         (col_s0),
        .flags       (flags_s0)
    );

    // Each entry packs {older line, newer line} for one column. On the
    // write-back the newer word slides into the older half and the new
    // pixel takes the newer half.
    gdfp_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata ({rd_new, s1_px_reg}),
        .re    (accept),
        .raddr (col_s0),
        .rdata (ram_rdata)
    );

    // A read that meets the write-back of the same column in the same cycle
    // returns stale data: forward the words being written instead.
    assign rd_old = fwd_hit_reg ? fwd_old_reg : ram_rdata[MW-1:PIXEL_W];
    assign rd_new = fwd_hit_reg ? fwd_new_reg : ram_rdata[PIXEL_W-1:0];

    gdfp_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_adv),
        .px      (s1_px_reg),
        .rd_old  (rd_old),
        .rd_new  (rd_new),
        .best    (best)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (s1_adv)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                fwd_hit_reg <= s1_adv && (s1_col_reg == col_s0);
            end
        end
    end

    // Payload: stage 1 holds unless a new item enters it; the output holds unless stage 1 advances
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= pixel;
            s1_col_reg   <= col_s0;
            s1_flags_reg <= flags_s0;
            fwd_old_reg  <= rd_new;
            fwd_new_reg  <= s1_px_reg;
        end
        if (s1_adv)
        begin
            dilated_value_reg <= s1_flags_reg.center_valid ? best : '0;
            out_flags_reg     <= s1_flags_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign dilated_value = dilated_value_reg;
    assign center_valid  = out_flags_reg.center_valid;
    assign frame_end     = out_flags_reg.frame_end;

    // Border results always carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !center_valid) |-> (dilated_value == '0))
        else $error("border result with nonzero value");

    // Forwarding only follows a write-back in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_hit_reg) |-> $past(s1_adv))
        else $error("forward hit without a write-back");

    // A full stage 1 behind a stalled output must block new items
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && result_valid && !result_ready) |-> !pixel_ready)
        else $error("item accepted into a blocked pipe");

    // A stage 1 item that cannot move stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stage 1 item lost");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the five-point grayscale dilation block. A scan-order
// model of the line stores and window taps predicts one result per accepted
// pixel item. A checker compares every accepted result against the oldest
// prediction. Directed frames cover the smallest window, clamped sizes and the
// longest line. Random phases follow, with the sender idling and the receiver
// stalling at different rates.
// ----------------------------------------------------------------------------

module tb;

    import gdfp_pkg::*;

    localparam int          MAX_LINE        = 1024;
    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned SCAN_CAP        = 96;    // longest random scan per setting

    // One result item as the block reports it
    typedef struct packed {
        pixel_t dilated_value;
        logic   center_valid;
        logic   frame_end;
    } dilation_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   pixel_valid;
    logic                   pixel_ready;
    pixel_t                 pixel;
    logic                   frame_start;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    pixel_t                 dilated_value;
    logic                   center_valid;
    logic                   frame_end;

    grayscale_dilation_five_point #(
        .MAX_LINE (MAX_LINE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel         (pixel),
        .frame_start   (frame_start),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .dilated_value (dilated_value),
        .center_valid  (center_valid),
        .frame_end     (frame_end)
    );

    // ------------------------------------------------------------------------
    // Scan-order model of the block: two line stores, four window taps and the
    // position counters. The defined flags mark store entries that hold a real
    // pixel, so the stimulus never lets a valid center read an unwritten entry.
    // ------------------------------------------------------------------------
    pixel_t                 older_row [MAX_LINE];
    pixel_t                 newer_row [MAX_LINE];
    bit                     older_defined [MAX_LINE];
    bit                     newer_defined [MAX_LINE];
    pixel_t                 taps [4];
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic [LEN_CFG_W-1:0]   line_length_reg;
    logic [CNT_CFG_W-1:0]   line_count_reg;

    dilation_t              expected_dilations [$];
    int unsigned            error_count = 0;
    int unsigned            cycle_count = 0;

    // Traffic shaping, set by the tests
    int unsigned            send_idle_pct  = 0;
    int unsigned            recv_stall_pct = 0;
    bit                     restart_pending = 1'b0;

    // Long receiver hold-off: the tests bump the trigger, the receiver counts
    int unsigned            hold_off_trigger = 0;
    int unsigned            hold_off_taken   = 0;
    int unsigned            hold_off_left    = 0;

    function automatic int unsigned used_length();
        if (line_length_reg < 3)
            return 3;
        if (line_length_reg > MAX_LINE)
            return MAX_LINE;
        return line_length_reg;
    endfunction

    function automatic int unsigned used_count();
        if (line_count_reg < 3)
            return 3;
        return line_count_reg;
    endfunction

    // True when both stores hold written pixels across a whole line of len
    function automatic bit stores_filled(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (!older_defined[i] || !newer_defined[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_model();
        for (int i = 0; i < MAX_LINE; i++)
        begin
            older_row[i]     = '0;
            newer_row[i]     = '0;
            older_defined[i] = 1'b0;
            newer_defined[i] = 1'b0;
        end
        for (int k = 0; k < 4; k++)
            taps[k] = '0;
        col_pos         = 0;
        row_pos         = 0;
        line_length_reg = LINE_LENGTH_RESET;
        line_count_reg  = LINE_COUNT_RESET;
    endtask

    // Advance the model by one pixel and return the result it causes
    function automatic dilation_t dilate_next(input pixel_t px, input logic fs);
        int unsigned len;
        int unsigned cnt;
        int unsigned c;
        int unsigned r;
        pixel_t      best;
        pixel_t      rd_old;
        pixel_t      rd_new;
        logic        interior;
        dilation_t   res;
        len = used_length();
        cnt = used_count();
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c        = col_pos;
        r        = row_pos;
        interior = (r >= 2) && (r < cnt) && (c >= 2) && (c < len);
        best     = px;
        for (int k = 0; k < 4; k++)
        begin
            if (taps[k] > best)
                best = taps[k];
        end
        rd_old = '0;
        rd_new = '0;
        if (c < MAX_LINE)
        begin
            // Cascade the column: newer line moves into the older store
            rd_old           = older_row[c];
            rd_new           = newer_row[c];
            older_row[c]     = rd_new;
            older_defined[c] = newer_defined[c];
            newer_row[c]     = px;
            newer_defined[c] = 1'b1;
        end
        taps[0] = taps[1];
        taps[1] = rd_old;
        taps[2] = taps[3];
        taps[3] = rd_new;
        res.frame_end = (c + 1 >= len) && (r + 1 >= cnt);
        if (c + 1 >= len)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= cnt) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
        res.center_valid  = interior;
        res.dilated_value = interior ? best : '0;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // End the run if the traffic stalls for good
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("grayscale_dilation_five_point regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted item, then pick the next ready level.
    // Signals are read right after the edge, so they still hold the values
    // that the edge sampled.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        dilation_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_dilations.size() == 0)
            begin
                $error("unexpected result item: dilated_value %0d center_valid %0b frame_end %0b",
                       dilated_value, center_valid, frame_end);
                error_count++;
            end
            else
            begin
                want = expected_dilations.pop_front();
                if (dilated_value !== want.dilated_value)
                begin
                    $error("dilated_value: expected %0d, actual %0d",
                           want.dilated_value, dilated_value);
                    error_count++;
                end
                if (center_valid !== want.center_valid)
                begin
                    $error("center_valid: expected %0b, actual %0b",
                           want.center_valid, center_valid);
                    error_count++;
                end
                if (frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, actual %0b",
                           want.frame_end, frame_end);
                    error_count++;
                end
            end
        end
        // Start a long hold-off when a test asks for one
        if (hold_off_trigger != hold_off_taken)
        begin
            hold_off_taken = hold_off_trigger;
            hold_off_left  = HOLD_OFF_CYCLES;
        end
        if (hold_off_left != 0)
        begin
            hold_off_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Sender side. All tasks start and end just after a rising edge. Valid
    // stays high between items; only a gap, a drain or hold_input lowers it.
    // ------------------------------------------------------------------------
    function automatic pixel_t random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return pixel_t'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input pixel_t px, input logic fs);
        logic fs_used;
        // Force a frame start after a setting that left the stores short
        fs_used         = fs | restart_pending;
        restart_pending = 1'b0;
        if ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        frame_start <= fs_used;
        do
            @(posedge clk);
        while (!pixel_ready);
        expected_dilations.push_back(dilate_next(px, fs_used));
    endtask

    // Send count pixels in scan order; noise_pct scatters stray frame starts
    task automatic send_scan(input int unsigned count, input bit start,
                             input int unsigned noise_pct);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(random_pixel(),
                       ((i == 0) && start) || ($urandom_range(99) < noise_pct));
    endtask

    task automatic hold_input();
        pixel_valid <= 1'b0;
    endtask

    // Drop valid and wait for every outstanding result, then let the pipe settle
    task automatic drain();
        hold_input();
        do
            @(posedge clk);
        while (expected_dilations.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == REG_LINE_LENGTH)
            line_length_reg = data[LEN_CFG_W-1:0];
        else
            line_count_reg = data[CNT_CFG_W-1:0];
    endtask

    // Write both sizes while idle. Keep the running frame only when the
    // stores already cover the new line; otherwise restart on the next item.
    task automatic configure(input logic [CFG_DATA_W-1:0] len_data,
                             input logic [CFG_DATA_W-1:0] cnt_data,
                             input bit keep_frame);
        drain();
        write_reg(REG_LINE_LENGTH, len_data);
        write_reg(REG_LINE_COUNT, cnt_data);
        restart_pending = !(keep_frame && stores_filled(used_length()));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Run with the reset sizes; every center here sits on the border
    task automatic test_reset_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pixel('1, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b0);
        send_pixel(8'h5A, 1'b0);
        send_pixel(8'hA5, 1'b0);
    endtask

    // Sizes below the minimum clamp to a 3x3 frame with one interior center
    task automatic test_smallest_window();
        pixel_t tap_frame [9] = '{8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0};
        configure(16'd2, 16'd0, 1'b0);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        // Ramp: the newest pixel wins
        for (int i = 0; i < 9; i++)
            send_pixel(pixel_t'(10 * (i + 1)), i == 0);
        // Natural wrap into the next frame; an old tap holds the maximum
        for (int i = 0; i < 9; i++)
            send_pixel(tap_frame[i], 1'b0);
        // All zero: a valid center with value zero
        for (int i = 0; i < 9; i++)
            send_pixel('0, i == 0);
    endtask

    // Longest line; upper data bits of line_length are dropped, so the first
    // stretch of the line must run on without an early line end
    task automatic test_longest_line();
        configure(16'hFC00, 16'd3, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_scan(MAX_LINE / 8, 1'b1, 0);
    endtask

    // Receiver holds off while the sender keeps offering; input must stall
    task automatic test_receiver_hold_off();
        configure(16'd6, 16'hFFFF, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_trigger++;
        send_scan(60, 1'b1, 0);
    endtask

    // Sender pauses mid-frame until the pipe has emptied, then resumes
    task automatic test_sender_pause();
        configure(16'd7, 16'd5, 1'b0);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        send_scan(20, 1'b1, 0);
        hold_input();
        do
            @(posedge clk);
        while (expected_dilations.size() != 0);
        send_scan(20, 1'b0, 0);
    endtask

    task automatic run_random_phase(input int unsigned send_pct,
                                    input int unsigned recv_pct,
                                    input int unsigned item_budget);
        int unsigned           sent;
        int unsigned           len_pick;
        int unsigned           scan_items;
        int unsigned           noise;
        bit                    keep;
        logic [CFG_DATA_W-1:0] len_data;
        logic [CFG_DATA_W-1:0] cnt_data;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent           = 0;
        while (sent < item_budget)
        begin
            case ($urandom_range(9))
                0:       len_pick = $urandom_range(2);
                1:       len_pick = $urandom_range(MAX_LINE + 1, 2047);
                default: len_pick = $urandom_range(3, 12);
            endcase
            // Bits above the register width are junk the block must drop
            len_data = {5'($urandom), 11'(len_pick)};
            case ($urandom_range(9))
                0:       cnt_data = 16'($urandom_range(2));
                1:       cnt_data = 16'hFFFF;
                2:       cnt_data = 16'($urandom);
                default: cnt_data = 16'($urandom_range(3, 8));
            endcase
            keep = ($urandom_range(2) != 0);
            configure(len_data, cnt_data, keep);
            // Mostly whole frames, a few times over; cap very large sizes
            scan_items = used_length() * used_count() * $urandom_range(1, 3);
            if (scan_items > SCAN_CAP)
                scan_items = SCAN_CAP;
            noise = ($urandom_range(6) == 0) ? 10 : 0;
            send_scan(scan_items, !keep, noise);
            sent += scan_items;
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 90);
        run_random_phase(85, 0, 90);
        run_random_phase(0, 85, 90);
        run_random_phase(24, 24, 90);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_LINE_LENGTH;
        cfg_data    = '0;
        pixel_valid = 1'b0;
        pixel       = '0;
        frame_start = 1'b0;
        clear_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_smallest_window();
        test_longest_line();
        test_receiver_hold_off();
        test_sender_pause();
        test_random_traffic();

        // Wait for the last results, then give stray items time to show up
        hold_input();
        do
            @(posedge clk);
        while (expected_dilations.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("grayscale_dilation_five_point regression: pass");
        else
            $display("grayscale_dilation_five_point regression: fail");
        $finish;
    end

endmodule
